>>> hdl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types, constants and the digit-to-ASCII mapping for the
// integer-to-radix-text block.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX_NUM = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] LETTER_BIAS  = 8'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD,
        S_SEND
    } irt_state_t;

    // sequencer to divider
    typedef struct packed {
        logic start;
    } irt_div_ctrl_t;

    // divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } irt_div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] letter_base;
        letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d > DIGIT_MAX_NUM) begin
            digit_char = {2'b00, d} - LETTER_BIAS + letter_base;
        end else begin
            digit_char = {2'b00, d} + CHAR_ZERO;
        end
    endfunction

endpackage

>>> hdl/irt_div.sv
// ----------------------------------------------------------------------------
// irt_div
// Restoring divider, one quotient bit per cycle, for a wide dividend and a
// small divisor (the base). Gives quotient and remainder.
// ----------------------------------------------------------------------------
module irt_div #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  irt_pkg::irt_div_ctrl_t        ctrl,
    input  logic [VALUE_BITS-1:0]         dividend,
    input  logic [irt_pkg::RADIX_W-1:0]   divisor,
    output irt_pkg::irt_div_stat_t        stat,
    output logic [VALUE_BITS-1:0]         quotient,
    output logic [irt_pkg::DIGIT_W-1:0]   remainder
);
    import irt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  ge;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/integer_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// Converts a signed integer to its ASCII text in a base from 2 to 36.
// ----------------------------------------------------------------------------
// One number is taken at a time; s_ready is low until its last character
// has been transferred. The number's magnitude is divided by the base once
// per digit on a one-bit-per-cycle divider, and each digit character then
// passes through a digit store read, an output register load and the
// transfer, which waits for m_ready; a '-' sign is loaded straight into the
// output register. The block returns to idle after the final character
// before the next number is taken. The text is a '-' for negative numbers,
// then the digits most significant first, with m_last on the final
// character; bases outside 2..36 are taken as 10 and zero gives "0".
// ----------------------------------------------------------------------------
module integer_to_radix_text_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_value,
    input  logic [irt_pkg::RADIX_W-1:0]   s_radix,
    input  logic                          s_upper_case,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [irt_pkg::CHAR_W-1:0]    m_char_out,
    output logic                          m_last
);
    import irt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    irt_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [RADIX_W-1:0]    base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic                  upper_reg, upper_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  s_xfer;
    logic                  m_xfer;
    logic [RADIX_W-1:0]    base_sel;
    logic [VALUE_BITS-1:0] mag;
    logic                  quo_zero;

    irt_div_ctrl_t         div_ctrl;
    irt_div_stat_t         div_stat;
    logic [VALUE_BITS-1:0] div_quo;
    logic [DIGIT_W-1:0]    div_rem;

    // digit store, least significant digit first
    logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];
    logic                  mem_we;
    logic [DIGIT_W-1:0]    mem_rdata;

    assign s_xfer   = s_valid && s_ready;
    assign m_xfer   = m_valid && m_ready;
    assign base_sel = (s_radix < RADIX_MIN || s_radix > RADIX_MAX) ? RADIX_DEFAULT : s_radix;
    // most negative value wraps to its unsigned magnitude
    assign mag      = s_value[VALUE_BITS-1] ? (~s_value + 1'b1) : s_value;
    assign quo_zero = (div_quo == '0);

    irt_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (work_reg),
        .divisor  (base_reg),
        .stat     (div_stat),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= div_rem;
        end
        mem_rdata <= digit_mem[idx_reg];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    if (!quo_zero) begin
                        state_next = S_START;
                    end else if (neg_reg) begin
                        state_next = S_SIGN;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_SIGN:  state_next = S_SEND;
            S_READ:  state_next = S_LOAD;
            S_LOAD:  state_next = S_SEND;
            S_SEND: begin
                if (m_ready) begin
                    state_next = last_reg ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        div_ctrl.start = 1'b0;
        mem_we         = 1'b0;
        work_next      = work_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    work_next  = mag;
                    base_next  = base_sel;
                    neg_next   = s_value[VALUE_BITS-1];
                    upper_next = s_upper_case;
                    cnt_next   = '0;
                end
            end
            S_START: begin
                div_ctrl.start = 1'b1;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    mem_we    = 1'b1;
                    work_next = div_quo;
                    cnt_next  = cnt_reg + 1'b1;
                    idx_next  = cnt_reg[IDX_W-1:0];
                end
            end
            S_SIGN: begin
                char_next = CHAR_MINUS;
                last_next = 1'b0;
            end
            S_READ: begin
            end
            S_LOAD: begin
                char_next = digit_char(mem_rdata, upper_reg);
                last_next = (idx_reg == '0);
                if (idx_reg != '0) begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_SEND: begin
                m_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        work_reg  <= work_next;
        base_reg  <= base_next;
        neg_reg   <= neg_next;
        upper_reg <= upper_next;
        idx_reg   <= idx_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign m_char_out = char_reg;
    assign m_last     = last_reg;

    // input and output never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a character is pending");

    // a transfer in always starts a division
    a_start_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_START))
        else $error("division not started after input transfer");

    // divider only reports completion while the sequencer waits for it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside division state");

    // divider is quiet while a new number may be taken
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    // the digit store never overflows
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count beyond store depth");

    // the final character returns the block to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_last) |=> s_ready)
        else $error("not idle after final character");

endmodule

>>> dv/integer_to_radix_text_checker.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_checker
// Watches both channels of the integer-to-radix-text block. Every number
// taken on the input side is rendered here into the characters the block
// should send. Each character on the output side is compared, field by
// field, against the oldest character still owed.
// ----------------------------------------------------------------------------
module integer_to_radix_text_checker #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_value,
    input  logic [irt_pkg::RADIX_W-1:0]   s_radix,
    input  logic                          s_upper_case,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [irt_pkg::CHAR_W-1:0]    m_char_out,
    input  logic                          m_last,
    output int                            chars_pending,
    output int                            mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import irt_pkg::*;

    localparam logic [CHAR_W-1:0] DECIMAL_DIGITS = 8'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    text_char_t owed_chars[$];
    int         errors = 0;

    function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (wide >= DECIMAL_DIGITS) begin
            return wide - DECIMAL_DIGITS + (upper ? CHAR_UPPER_A : CHAR_LOWER_A);
        end
        return wide + CHAR_ZERO;
    endfunction

    // renders one number into the queue of characters still owed
    function automatic void render_text(input logic [VALUE_BITS-1:0] value,
                                        input logic [RADIX_W-1:0] radix,
                                        input logic upper);
        logic [VALUE_BITS-1:0] work;
        logic [VALUE_BITS-1:0] base;
        logic [DIGIT_W-1:0]    digits [VALUE_BITS];
        logic                  negative;
        text_char_t            c;
        int                    n;
        negative = value[VALUE_BITS-1];
        // most negative value wraps to its own unsigned magnitude here
        work = negative ? -value : value;
        base = VALUE_BITS'((radix < RADIX_MIN || radix > RADIX_MAX) ? RADIX_DEFAULT : radix);
        n = 0;
        do begin
            digits[n] = DIGIT_W'(work % base);
            n++;
            work = work / base;
        end while (work != 0);
        if (negative) begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            owed_chars.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch   = ascii_digit(digits[k], upper);
            c.last = (k == 0);
            owed_chars.push_back(c);
        end
    endfunction

    always @(posedge aclk) begin : watch_channels
        text_char_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                render_text(s_value, s_radix, s_upper_case);
            end
            if (m_valid && m_ready) begin
                if (owed_chars.size() == 0) begin
                    $error("unexpected transfer: char_out %h, last %b", m_char_out, m_last);
                    errors++;
                end else begin
                    want = owed_chars.pop_front();
                    if (m_char_out !== want.ch) begin
                        $error("char_out mismatch: expected %h, actual %h", want.ch, m_char_out);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last mismatch: expected %b, actual %b", want.last, m_last);
                        errors++;
                    end
                end
            end
        end
        chars_pending  <= owed_chars.size();
        mismatch_count <= errors;
    end

endmodule

>>> dv/integer_to_radix_text_top_test.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_top_test
// Stimulus and verdict for the integer-to-radix-text block. A directed set
// covers zero, the signed extremes, every base edge and both letter cases;
// a random set follows, with random idling on both channels and a stretch
// with none. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import irt_pkg::*;

    localparam int VALUE_BITS   = 32;
    localparam int RANDOM_ITEMS = 270;
    localparam int IDLE_PCT     = 26;
    localparam int DRAIN_CYCLES = 2 * (VALUE_BITS + 5);
    localparam int CYCLE_LIMIT  = 2_000_000;

    localparam logic signed [VALUE_BITS-1:0] MAX_VALUE = 32'sh7fff_ffff;
    localparam logic signed [VALUE_BITS-1:0] MIN_VALUE = 32'sh8000_0000;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic signed [VALUE_BITS-1:0]  s_value      = '0;
    logic [RADIX_W-1:0]            s_radix      = '0;
    logic                          s_upper_case = 1'b0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic [CHAR_W-1:0]             m_char_out;
    logic                          m_last;
    logic                          quiet_stretch = 1'b0;
    int                            chars_pending;
    int                            mismatch_count;
    int unsigned                   cycles;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    integer_to_radix_text_top #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .s_radix      (s_radix),
        .s_upper_case (s_upper_case),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_last       (m_last)
    );

    integer_to_radix_text_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_radix        (s_radix),
        .s_upper_case   (s_upper_case),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_out     (m_char_out),
        .m_last         (m_last),
        .chars_pending  (chars_pending),
        .mismatch_count (mismatch_count)
    );

    always @(posedge aclk) begin
        m_ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_number(input logic signed [VALUE_BITS-1:0] value,
                               input logic [RADIX_W-1:0] radix,
                               input logic upper);
        if (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            s_value <= $urandom;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid      <= 1'b1;
        s_value      <= value;
        s_radix      <= radix;
        s_upper_case <= upper;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // holds the input side off until every owed character has been transferred
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_pending != 0);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned sel;
        logic signed [VALUE_BITS-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            v = $urandom_range(0, 1000);
        end else if (sel < 55) begin
            v = $urandom_range(0, 1_000_000);
        end else if (sel < 85) begin
            return $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0: return MAX_VALUE;
                1: return MIN_VALUE;
                2: return MIN_VALUE + 1;
                default: v = 0;
            endcase
        end
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        end else if (sel < 78) begin
            return RADIX_MIN;
        end
        return RADIX_W'($urandom_range(0, 63));
    endfunction

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge aclk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, unit values and the signed extremes
        send_number(0, RADIX_DEFAULT, 1'b0);
        send_number(0, RADIX_MIN, 1'b1);
        send_number(1, RADIX_MIN, 1'b0);
        send_number(-1, RADIX_DEFAULT, 1'b0);
        send_number(-1, RADIX_MIN, 1'b1);
        send_number(MAX_VALUE, RADIX_DEFAULT, 1'b0);
        send_number(MAX_VALUE, RADIX_MIN, 1'b0);
        send_number(MAX_VALUE, RADIX_MAX, 1'b1);
        send_number(MAX_VALUE, 6'd16, 1'b0);
        send_number(MIN_VALUE, RADIX_DEFAULT, 1'b0);
        send_number(MIN_VALUE, RADIX_MIN, 1'b1);
        send_number(MIN_VALUE, 6'd16, 1'b1);
        send_number(MIN_VALUE, RADIX_MAX, 1'b0);
        // bases outside the legal range fall back to decimal
        send_number(-12345, 6'd0, 1'b0);
        send_number(-12345, 6'd1, 1'b1);
        send_number(67890, 6'd37, 1'b0);
        send_number(67890, 6'd63, 1'b1);
        // letter digits at both ends of the alphabet, both cases
        send_number(35, RADIX_MAX, 1'b0);
        send_number(35, RADIX_MAX, 1'b1);
        send_number(10, 6'd11, 1'b0);
        send_number(255, 6'd16, 1'b1);
        send_number(-1295, RADIX_MAX, 1'b1);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 110) begin
                quiet_stretch <= 1'b1;
            end else if (i == 170) begin
                quiet_stretch <= 1'b0;
            end
            if (i == 200) begin
                wait_drained();
            end
            send_number(pick_value(), pick_radix(), 1'($urandom_range(0, 1)));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
